// ----- rtl/kmp_pkg.sv -----
// Shared types and constants for the streaming substring search block.
package kmp_pkg;

	// Depth of the queue between the front end and the back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Codes of the action field.
	localparam logic ACT_PATTERN = 1'b0;
	localparam logic ACT_TEXT    = 1'b1;

	// Codes of the status field.
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	// One classified item as it travels from the front end to the back end.
	typedef struct packed {
		logic       is_text;
		logic       start;
		logic       last;
		logic [7:0] symbol;
	} item_t;

	// Back end sequencer states.
	typedef enum logic {
		ST_IDLE,
		ST_CMP
	} state_t;

endpackage

// ----- rtl/kmp_front.sv -----
// Front end: accepts input transactions and marks the first byte of each pattern.
module kmp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            action,
	input  logic [7:0]      symbol,
	input  logic            last,
	input  logic            q_full,
	output logic            push,
	output kmp_pkg::item_t  push_item
);

	logic new_pattern_q;

	// Accept whenever the queue has room.
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Classify the item: a pattern byte seen after a text byte or a final
	// pattern byte opens a new pattern.
	always_comb begin
		push_item.is_text = (action == kmp_pkg::ACT_TEXT);
		push_item.start   = (action == kmp_pkg::ACT_PATTERN) && new_pattern_q;
		push_item.last    = last;
		push_item.symbol  = symbol;
	end

	// Track whether the next pattern byte starts a fresh pattern.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_pattern_q <= 1'b1;
		end else if (push) begin
			if (action == kmp_pkg::ACT_TEXT) begin
				new_pattern_q <= 1'b1;
			end else begin
				new_pattern_q <= last;
			end
		end
	end

endmodule

// ----- rtl/kmp_queue.sv -----
// Short first-in first-out queue of classified items between front and back ends.
module kmp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kmp_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output kmp_pkg::item_t  pop_item
);

	localparam int PW = kmp_pkg::QUEUE_PTR_W;
	localparam int CW = kmp_pkg::QUEUE_CNT_W;

	kmp_pkg::item_t         entry_q [kmp_pkg::QUEUE_DEPTH];
	logic [PW-1:0]          wr_ptr_q;
	logic [PW-1:0]          rd_ptr_q;
	logic [CW-1:0]          count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full      = (count_q == CW'(kmp_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_item  = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Entry storage, written at the write pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(kmp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(kmp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/kmp_back.sv -----
// Back end: pattern and failure table memories, match sequencer and result register.
module kmp_back #(
	parameter int MAX_PATTERN = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  kmp_pkg::item_t  q_item,
	output logic            q_pop,
	output logic            busy,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            found,
	output logic            text_done,
	output logic            status
);

	localparam int LW = $clog2(MAX_PATTERN + 1);
	localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// Memories.
	logic [7:0]     store_mem [MAX_PATTERN];
	logic [AW-1:0]  prefix_mem [MAX_PATTERN];
	logic [7:0]     store_rd;
	logic [AW-1:0]  prefix_rd;
	logic           store_we;
	logic [AW-1:0]  store_wa;
	logic           prefix_we;
	logic [AW-1:0]  prefix_wa;
	logic [AW-1:0]  prefix_wd;
	logic [AW-1:0]  raddr;

	// Sequencer and match state.
	kmp_pkg::state_t state_q, state_d;
	kmp_pkg::item_t  item_q, item_d;
	logic [AW-1:0]   k_q, k_d;
	logic [AW-1:0]   pos_q, pos_d;
	logic [LW-1:0]   plen_q, plen_d;
	logic [AW-1:0]   build_q, build_d;
	logic [AW-1:0]   match_q, match_d;
	logic            found_q, found_d;
	logic            ovf_q, ovf_d;

	// Result register.
	logic            out_valid_q;
	logic            out_found_q;
	logic            out_done_q;
	logic            out_status_q;
	logic            emit;
	logic            emit_found;
	logic            emit_done;
	logic            out_free;

	// Working values of the current step.
	logic            start;
	logic [LW-1:0]   plen_eff;
	logic [AW-1:0]   build_eff;
	logic            hit;
	logic [LW-1:0]   k_next;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign found     = out_found_q;
	assign text_done = out_done_q;
	assign status    = out_status_q;
	assign busy      = (state_q == kmp_pkg::ST_CMP);
	assign start     = q_item.start && !q_item.is_text;
	assign plen_eff  = start ? '0 : plen_q;
	assign build_eff = start ? '0 : build_q;
	assign hit       = (store_rd == item_q.symbol);
	assign k_next    = LW'(k_q) + LW'(hit);

	// Pattern store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_wa] <= q_item.symbol;
		end
		store_rd <= store_mem[raddr];
	end

	// Failure table: read one entry below the store address.
	always_ff @(posedge clk) begin
		if (prefix_we) begin
			prefix_mem[prefix_wa] <= prefix_wd;
		end
		prefix_rd <= prefix_mem[raddr - 1'b1];
	end

	// Next state, memory control and result selection.
	always_comb begin
		state_d    = state_q;
		item_d     = item_q;
		k_d        = k_q;
		pos_d      = pos_q;
		plen_d     = plen_q;
		build_d    = build_q;
		match_d    = match_q;
		found_d    = found_q;
		ovf_d      = ovf_q;
		q_pop      = 1'b0;
		emit       = 1'b0;
		emit_found = 1'b0;
		emit_done  = 1'b0;
		store_we   = 1'b0;
		store_wa   = plen_eff[AW-1:0];
		prefix_we  = 1'b0;
		prefix_wa  = pos_q;
		prefix_wd  = k_next[AW-1:0];
		raddr      = k_q;

		case (state_q)
			kmp_pkg::ST_IDLE: begin
				raddr = q_item.is_text ? match_q : build_eff;
				if (q_valid && out_free) begin
					q_pop  = 1'b1;
					item_d = q_item;
					if (!q_item.is_text) begin
						// Pattern byte; a new pattern drops the old match state.
						if (start) begin
							build_d = '0;
							ovf_d   = 1'b0;
							match_d = '0;
							found_d = 1'b0;
							plen_d  = '0;
						end
						if (plen_eff >= LW'(MAX_PATTERN)) begin
							ovf_d = 1'b1;
							emit  = 1'b1;
						end else if (plen_eff == '0) begin
							store_we  = 1'b1;
							prefix_we = 1'b1;
							prefix_wa = '0;
							prefix_wd = '0;
							build_d   = '0;
							plen_d    = LW'(1);
							emit      = 1'b1;
						end else begin
							store_we = 1'b1;
							k_d      = build_eff;
							pos_d    = plen_eff[AW-1:0];
							state_d  = kmp_pkg::ST_CMP;
						end
					end else if (plen_q == '0 || found_q) begin
						// Empty pattern, or a match already seen in this text.
						emit       = 1'b1;
						emit_found = 1'b1;
						emit_done  = q_item.last;
						found_d    = !q_item.last;
						if (q_item.last) begin
							match_d = '0;
						end
					end else begin
						k_d     = match_q;
						state_d = kmp_pkg::ST_CMP;
					end
				end
			end

			kmp_pkg::ST_CMP: begin
				if (k_q != '0 && !hit) begin
					// Mismatch: fall back through the failure table.
					k_d   = prefix_rd;
					raddr = prefix_rd;
				end else if (!item_q.is_text) begin
					// Close the failure table entry for the new pattern byte.
					prefix_we = 1'b1;
					build_d   = k_next[AW-1:0];
					plen_d    = LW'(pos_q) + LW'(1);
					emit      = 1'b1;
					state_d   = kmp_pkg::ST_IDLE;
				end else begin
					// Advance the text match; a full length is a find.
					emit      = 1'b1;
					emit_done = item_q.last;
					state_d   = kmp_pkg::ST_IDLE;
					if (k_next >= plen_q) begin
						emit_found = 1'b1;
						match_d    = '0;
					end else begin
						match_d = k_next[AW-1:0];
					end
					found_d = emit_found;
					if (item_q.last) begin
						match_d = '0;
						found_d = 1'b0;
					end
				end
			end

			default: begin
				state_d = kmp_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmp_pkg::ST_IDLE;
			plen_q  <= '0;
			build_q <= '0;
			match_q <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			plen_q  <= plen_d;
			build_q <= build_d;
			match_q <= match_d;
			found_q <= found_d;
			ovf_q   <= ovf_d;
		end
	end

	// Working item and walk registers.
	always_ff @(posedge clk) begin
		item_q <= item_d;
		k_q    <= k_d;
		pos_q  <= pos_d;
	end

	// Result register: loads a result, empties when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_found_q  <= emit_found;
			out_done_q   <= emit_done;
			out_status_q <= ovf_d ? kmp_pkg::STATUS_OVERFLOW : kmp_pkg::STATUS_OK;
		end
	end

endmodule

// ----- rtl/kmp_substring_search.sv -----
// Path from input to result: the queue entry, then the result register for stored, overflowed or settled
// bytes; a compared byte also passes the compare state, once more per failure-table fallback step.
// The back end sequencer settles a byte that needs no compare from the idle state, and a compared byte
// in the compare state; each fallback is one registered table read. No new byte is taken during a walk.
// Reset (arst_n low) clears control state and the queue; the pattern store and the
// failure table hold whatever they held and are only read where written, so no clearing pass.
module kmp_substring_search #(
	parameter int MAX_PATTERN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] symbol,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	output logic       text_done,
	output logic       status
);

	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	logic           busy;
	kmp_pkg::item_t push_item;
	kmp_pkg::item_t q_item;

	// Front end: acceptance and classification.
	kmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.symbol    (symbol),
		.last      (last),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Queue decoupling the two ends.
	kmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	// Back end: matching and results.
	kmp_back #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.text_done (text_done),
		.status    (status)
	);

	// The result register is empty while a compare walk is in progress.
	a_walk_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !out_valid)
		else $error("result pending during a compare walk");

	// An item leaves the queue only when its result has somewhere to go.
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (!out_valid || !out_stall)))
		else $error("item taken from queue without room for its result");

	// A new result appears only after a pop or a finished walk.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(q_pop) || $past(busy)))
		else $error("result appeared with no item behind it");

endmodule
